// ===== sv/signed_int_to_decimal_ascii_top_macros.svh =====
// assertion macros used by the checker file
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define SITDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sitda assertion failed");

// next-cycle implication
`define SITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sitda assertion failed");

`endif

// ===== sv/sitda_pkg.sv =====
// shared types, constants and helpers for the signed integer to decimal text block
// no dependencies
package sitda_pkg;

	localparam int DEF_INPUT_BITS = 32;
	// bits of the magnitude folded into the bcd register per conversion cycle
	localparam int BITS_PER_STEP = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic skip_digit;
		logic emit_sign;
		logic emit_digit;
	} dp_cmd_t;

	typedef struct packed {
		logic neg;
		logic step_last;
		logic top_zero;
		logic digit_last;
		logic out_free;
	} dp_status_t;

	// shift-add-3 correction of one bcd digit
	function automatic logic [3:0] add3(input logic [3:0] d);
		add3 = (d >= 4'd5) ? (d + 4'd3) : d;
	endfunction

endpackage

// ===== sv/signed_int_to_decimal_ascii_top.sv =====
// sequence: a request is accepted, the magnitude is converted to bcd in conversion steps,
// leading zeros are dropped while at least one digit is kept, then a minus if negative and
// the digits go out, each when the output is free; there are 10 digit positions at 32 bits;
// the conversion steps plus the walk over every digit position, one per cycle while the output
// is free, set the rate; the next request is taken the cycle after the final character enters
// the output register
// reset: arst_n clears the state machine and the output valid; no data is held over
module signed_int_to_decimal_ascii_top
	import sitda_pkg::*;
#(
	parameter int INPUT_BITS = DEF_INPUT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [INPUT_BITS-1:0] value,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic [7:0]                   character,
	output logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall
);

	dp_cmd_t    cmd;
	dp_status_t status;

	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sitda_dp #(
		.INPUT_BITS (INPUT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.character (character),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

// ===== sv/sitda_ctrl.sv =====
// controller state machine: sequences load, conversion, leading zero skip and emission
// depends on sitda_pkg
module sitda_ctrl
	import sitda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (status.step_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keeping at least one digit
				if (status.top_zero && !status.digit_last) begin
					cmd.skip_digit = 1'b1;
				end else if (status.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.digit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== sv/sitda_dp.sv =====
// datapath: magnitude register, double-dabble bcd converter, digit shifter, output register
// depends on sitda_pkg
module sitda_dp
	import sitda_pkg::*;
#(
	parameter int INPUT_BITS = DEF_INPUT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [INPUT_BITS-1:0] value,
	input  dp_cmd_t                      cmd,
	output dp_status_t                   status,
	output logic [7:0]                   character,
	output logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall
);

	localparam int STEPS   = (INPUT_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD     = STEPS * BITS_PER_STEP;
	// digit count of 2^INPUT_BITS - 1, log10(2) ~ 1233/4096
	localparam int NDIG    = ((INPUT_BITS * 1233) >> 12) + 1;
	localparam int BCD_W   = NDIG * 4;
	localparam int STEP_CW = $clog2(STEPS);
	localparam int DIG_CW  = $clog2(NDIG + 1);

	logic [PAD-1:0]        mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  neg_q;
	logic [STEP_CW-1:0]    step_q;
	logic [DIG_CW-1:0]     dig_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  ovalid_q;

	logic [INPUT_BITS-1:0] raw;
	logic [INPUT_BITS-1:0] mag_in;
	logic [BCD_W-1:0]      bcd_nx;
	logic [PAD-1:0]        mag_nx;
	logic [3:0]            top_digit;
	logic                  push;

	assign raw       = $unsigned(value);
	assign mag_in    = raw[INPUT_BITS-1] ? (~raw + 1'b1) : raw;
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign push      = cmd.emit_sign | cmd.emit_digit;

	// one conversion step: BITS_PER_STEP add-3 and shift rounds
	always_comb begin
		bcd_nx = bcd_q;
		mag_nx = mag_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			for (int d = 0; d < NDIG; d++) begin
				bcd_nx[d*4 +: 4] = add3(bcd_nx[d*4 +: 4]);
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], mag_nx[PAD-1]};
			mag_nx = {mag_nx[PAD-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q  <= PAD'(mag_in);
			neg_q  <= raw[INPUT_BITS-1];
			bcd_q  <= '0;
			step_q <= '0;
			dig_q  <= DIG_CW'(NDIG);
		end else if (cmd.conv_step) begin
			mag_q  <= mag_nx;
			bcd_q  <= bcd_nx;
			step_q <= step_q + 1'b1;
		end else if (cmd.skip_digit || cmd.emit_digit) begin
			bcd_q  <= {bcd_q[BCD_W-5:0], 4'b0000};
			dig_q  <= dig_q - 1'b1;
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + {4'b0000, top_digit};
			last_q <= status.digit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (push) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	assign status.neg        = neg_q;
	assign status.step_last  = (step_q == STEP_CW'(STEPS - 1));
	assign status.top_zero   = (top_digit == 4'd0);
	assign status.digit_last = (dig_q == DIG_CW'(1));
	assign status.out_free   = !ovalid_q || !out_stall;

	assign character = char_q;
	assign last      = last_q;
	assign out_valid = ovalid_q;

endmodule

// ===== sv/sitda_chk.sv =====
// port-level checker for the signed integer to decimal text block, bound to the top level
// depends on signed_int_to_decimal_ascii_top_macros.svh
`include "signed_int_to_decimal_ascii_top_macros.svh"

module sitda_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] character,
	input logic       last,
	input logic       out_valid,
	input logic       out_stall
);

	// a stalled result keeps its payload
	`SITDA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(character) && $stable(last))

	// only '-' or a decimal digit is ever sent
	`SITDA_ASSERT_NOW(a_char_legal, clk, arst_n, out_valid, (character == 8'd45) || ((character >= 8'd48) && (character <= 8'd57)))

	// the sign never closes a run
	`SITDA_ASSERT_NOW(a_sign_not_last, clk, arst_n, out_valid && (character == 8'd45), !last)

	// busy right after a request is taken
	`SITDA_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)

	// no new request is taken while a non-final character is on the output
	`SITDA_ASSERT_NOW(a_stall_mid_run, clk, arst_n, out_valid && !last, in_stall)

endmodule

bind signed_int_to_decimal_ascii_top sitda_chk u_chk (.*);

// ===== bench/testbench.sv =====
// testbench for signed_int_to_decimal_ascii_top: signed 32-bit values in, decimal ascii chars out
// checks every character and its last flag against typed text or a behavioral text predictor
// depends on sitda_pkg and the block's rtl
module testbench;
	import sitda_pkg::*;

	localparam int NUM_RANDOM   = 450;
	localparam int CALM_TAIL    = 60;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 40;
	localparam int STUCK_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0] code;
		logic       tail;
	} text_char_t;

	typedef struct {
		logic signed [31:0] val;
		string              txt;
	} dir_case_t;

	logic               clk;
	logic               arst_n;
	logic signed [31:0] value;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         character;
	logic               last;
	logic               out_valid;
	logic               out_stall;

	text_char_t expected_text[$];
	int         errors = 0;
	bit         idle_on = 1'b1;
	bit         hold_req = 1'b0;

	// empty text means the row is checked against the predictor
	dir_case_t dir_cases [20] = '{
		'{32'sd0,           "0"},
		'{32'sd1,           "1"},
		'{-32'sd1,          "-1"},
		'{32'sd9,           "9"},
		'{32'sd10,          "10"},
		'{-32'sd10,         "-10"},
		'{32'sh7FFFFFFF,    "2147483647"},
		'{32'sh80000000,    "-2147483648"},
		'{32'sh80000001,    "-2147483647"},
		'{32'sd1000000000,  "1000000000"},
		'{32'sd999999999,   "999999999"},
		'{-32'sd999999999,  ""},
		'{32'sd123456789,   ""},
		'{-32'sd5,          "-5"},
		'{32'sd100,         ""},
		'{32'sh55555555,    ""},
		'{32'shAAAAAAAA,    ""},
		'{32'sh0000FFFF,    ""},
		'{32'shFFFF0000,    ""},
		'{32'sd7,           "7"}
	};

	signed_int_to_decimal_ascii_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.character (character),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decimal text of one value: optional minus, then digits msd first
	function automatic void predict_text(input logic signed [31:0] v);
		longint     mag;
		logic [7:0] digs[$];
		logic       neg;
		int         i;
		neg = v[31];
		mag = neg ? -longint'(v) : longint'(v);
		do begin
			digs.push_front(CHAR_ZERO + 8'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (neg)
			expected_text.push_back('{CHAR_MINUS, 1'b0});
		for (i = 0; i < digs.size(); i++)
			expected_text.push_back('{digs[i], i == digs.size() - 1});
	endfunction

	function automatic logic signed [31:0] pick_value();
		longint p;
		longint t;
		int     kind;
		kind = $urandom_range(0, 9);
		p = 1;
		case (kind)
			0, 1, 2, 3: begin
				return $urandom;
			end
			4, 5: begin
				t = $urandom_range(0, 999);
			end
			6: begin
				repeat ($urandom_range(0, 9)) p = p * 10;
				t = p + $urandom_range(0, 2) - 1;
			end
			7: begin
				if ($urandom_range(0, 1))
					return 32'sh7FFFFFFF - $urandom_range(0, 20);
				return 32'sh80000000 + $urandom_range(0, 20);
			end
			default: begin
				t = $urandom_range(0, 99999);
			end
		endcase
		if ($urandom_range(0, 1))
			t = -t;
		return 32'(t);
	endfunction

	// offer one request and hold it until taken; typed text overrides the predictor
	task automatic offer(input logic signed [31:0] v, input string txt);
		int gap;
		int i;
		if (idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		if (txt.len() == 0) begin
			predict_text(v);
		end else begin
			for (i = 0; i < txt.len(); i++)
				expected_text.push_back('{8'(txt[i]), i == txt.len() - 1});
		end
	endtask

	initial begin
		int n;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_cases[n])
			offer(dir_cases[n].val, dir_cases[n].txt);
		hold_req = 1'b1;
		for (n = 0; n < NUM_RANDOM; n++) begin
			if (n == NUM_RANDOM - CALM_TAIL)
				idle_on = 1'b0;
			offer(pick_value(), "");
		end
		in_valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// output side: random stall bursts, one long hold-off to back the block up
	initial begin
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				errors++;
				$display("%0t: unexpected char: expected none, actual code %0d last %0b",
					$realtime, character, last);
			end else begin
				want = expected_text.pop_front();
				if (character !== want.code) begin
					errors++;
					$display("%0t: character mismatch: expected %0d, actual %0d",
						$realtime, want.code, character);
				end
				if (last !== want.tail) begin
					errors++;
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$realtime, want.tail, last);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t: no transfer for %0d cycles", $realtime, STUCK_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
